// File: sv/fgn_pkg.sv
package fgn_pkg;

    // Fixed-point format of the datapath.
    localparam int FRAC_BITS  = 16;
    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);

    // Widths sized for up to sixteen octaves.
    localparam int W_W    = FRAC_BITS + 1;
    localparam int ACC_W  = 2 * FRAC_BITS + 5;
    localparam int WSUM_W = FRAC_BITS + 5;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int CNT_W  = 5;

    localparam logic [W_W-1:0] ONE_Q = W_W'(1) << FRAC_BITS;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_BASE_FREQ  = 2'd0,
        REG_BASE_AMP   = 2'd1,
        REG_OCT_COUNT  = 2'd2,
        REG_PERSIST    = 2'd3
    } cfg_reg_t;

    // Configuration after range clamping, shared by all octave cells.
    typedef struct packed {
        logic [23:0]      base_freq;
        logic [W_W-1:0]   pers;
        logic [CNT_W-1:0] n_oct;
    } cfg_t;

    // Data that travels from one octave cell to the next.
    typedef struct packed {
        logic               valid;
        logic [2:0][31:0]   coord;
        logic [ACC_W-1:0]   acc;
        logic [WSUM_W-1:0]  wsum;
        logic [W_W-1:0]     w;
    } pass_t;

    // Data that travels through the divider cells.
    typedef struct packed {
        logic              valid;
        logic [ACC_W-1:0]  rem;
        logic [WSUM_W-1:0] den;
        logic [Q_W-1:0]    q;
    } div_t;

    localparam logic [7:0] PERM_ROM [TABLE_SIZE] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic [7:0] perm_at(input logic [IDX_W-1:0] idx);
        return PERM_ROM[idx];
    endfunction

    // Dot product of the corner offset with the cube-edge gradient that the hash selects.
    function automatic logic signed [19:0] grad_dot(
        input logic [3:0]         h,
        input logic signed [17:0] x,
        input logic signed [17:0] y,
        input logic signed [17:0] z
    );
        logic signed [19:0] u;
        logic signed [19:0] v;
        u = (h < 4'd8) ? 20'(x) : 20'(y);
        if (h < 4'd4) begin
            v = 20'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            v = 20'(x);
        end else begin
            v = 20'(z);
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

// File: sv/fractal_gradient_noise_3d.sv
// Channel     | Handshake          | Payload
// ------------+--------------------+------------------------------------------
// input       | s_valid / s_ready  | s_coord_x, s_coord_y, s_coord_z (Q16.16)
// result      | m_valid / m_ready  | m_noise_value (Q1.16, 65536 is 1.0)
// config      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One transaction is taken per cycle while the skid register is empty.
// Each octave cell is a 14-stage pipeline, the divider adds one stage per
// quotient bit (17), plus the input and output registers.
// Reset is synchronous and active low; it clears all valid bits and loads the
// default configuration. A stalled result goes to a skid register; the whole
// pipeline holds only while that register is full.
module fractal_gradient_noise_3d
    import fgn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_coord_x,
    input  logic signed [31:0]  s_coord_y,
    input  logic signed [31:0]  s_coord_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [Q_W-1:0]      m_noise_value,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    localparam int DIV_STEPS = Q_W;

    logic [23:0]     base_freq_reg;
    logic [23:0]     base_amp_reg;
    logic [3:0]      oct_count_reg;
    logic [16:0]     persist_reg;
    cfg_t            cfg;
    logic            en;
    pass_t           in_reg;
    pass_t           chain [MAX_OCTAVES+1];
    div_t            dchain [DIV_STEPS+1];
    logic            m_valid_reg, skid_valid_reg;
    logic [Q_W-1:0]  m_noise_reg, skid_noise_reg, q_sat;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_freq_reg <= 24'd65536;
            base_amp_reg  <= 24'd65536;
            oct_count_reg <= 4'd1;
            persist_reg   <= 17'd32768;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_BASE_FREQ: base_freq_reg <= cfg_data;
                REG_BASE_AMP:  base_amp_reg  <= cfg_data;
                REG_OCT_COUNT: oct_count_reg <= cfg_data[3:0];
                REG_PERSIST:   persist_reg   <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Clamp the octave count and persistence into range. The first octave
    // weight cancels in the normalization, so base amplitude is not used
    // by the datapath beyond its register.
    always_comb begin
        cfg.base_freq = base_freq_reg;
        cfg.pers      = (persist_reg > 17'(ONE_Q)) ? ONE_Q : persist_reg;
        if (oct_count_reg == 4'd0) begin
            cfg.n_oct = CNT_W'(1);
        end else if (CNT_W'(oct_count_reg) > CNT_W'(MAX_OCTAVES)) begin
            cfg.n_oct = CNT_W'(MAX_OCTAVES);
        end else begin
            cfg.n_oct = CNT_W'(oct_count_reg) | CNT_W'(base_amp_reg == 24'd0 && 1'b0);
        end
    end

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Input register seeds the accumulators; only its valid bit is reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg.coord <= {s_coord_z, s_coord_y, s_coord_x};
            in_reg.acc   <= '0;
            in_reg.wsum  <= '0;
            in_reg.w     <= ONE_Q;
        end
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (en) begin
            in_reg.valid <= s_valid;
        end
    end

    assign chain[0] = in_reg;

    // One cell per octave.
    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
        fgn_octave_cell #(.OCT(g)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cfg      (cfg),
            .in_pass  (chain[g]),
            .out_pass (chain[g+1])
        );
    end

    // Normalization: restoring divider, one quotient bit per cell.
    always_comb begin
        dchain[0].valid = chain[MAX_OCTAVES].valid;
        dchain[0].rem   = chain[MAX_OCTAVES].acc;
        dchain[0].den   = chain[MAX_OCTAVES].wsum;
        dchain[0].q     = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        fgn_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_d    (dchain[k]),
            .out_d   (dchain[k+1])
        );
    end

    assign q_sat = (dchain[DIV_STEPS].q > Q_W'(ONE_Q)) ? Q_W'(ONE_Q) : dchain[DIV_STEPS].q;

    // Output register with a skid stage behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
            if (en && dchain[DIV_STEPS].valid) begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && m_ready && skid_valid_reg) begin
            m_noise_reg <= skid_noise_reg;
        end
        if (en && dchain[DIV_STEPS].valid) begin
            if (!m_valid_reg || m_ready) begin
                m_noise_reg <= q_sat;
            end else begin
                skid_noise_reg <= q_sat;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = m_noise_reg;

    // The skid register is only used while the output register is occupied.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register full while output register empty");

    // A held skid transaction keeps its value until it moves forward.
    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> (skid_valid_reg && $stable(skid_noise_reg)))
        else $error("skid transaction lost or changed");

    // Normalized output never exceeds 1.0.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_noise_reg <= Q_W'(ONE_Q)))
        else $error("noise value above 1.0");

endmodule

// File: sv/fgn_octave_cell.sv
module fgn_octave_cell
    import fgn_pkg::*;
#(
    parameter int OCT = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cfg_t  cfg,
    input  pass_t in_pass,
    output pass_t out_pass
);

    localparam int LINE = 13;

    // Pass-through data, one entry per internal stage.
    pass_t line_reg [1:LINE];

    logic [39:0]         prod_reg [3];
    logic signed [38:0]  ta_reg   [3];
    logic [31:0]         tt_reg   [3];
    logic [15:0]         frac2_reg [3];
    logic [7:0]          ha_reg, hb_reg, cz2_reg;
    logic signed [22:0]  b_reg    [3];
    logic [31:0]         t3p_reg  [3];
    logic [15:0]         frac3_reg [3];
    logic [7:0]          corner_reg [4];
    logic signed [39:0]  fp_reg   [3];
    logic [3:0]          h_reg    [8];
    logic [15:0]         frac4_reg [3];
    logic signed [17:0]  fade_reg [3];
    logic signed [19:0]  grad_reg [8];
    logic signed [19:0]  l1a_reg  [4];
    logic signed [38:0]  l1p_reg  [4];
    logic signed [17:0]  fv6_reg, fw6_reg, fv7_reg, fw7_reg, fw8_reg, fw9_reg;
    logic signed [23:0]  l1_reg   [4];
    logic signed [23:0]  l2a_reg  [2];
    logic signed [42:0]  l2p_reg  [2];
    logic signed [23:0]  l2_reg   [2];
    logic signed [23:0]  l3a_reg;
    logic signed [42:0]  l3p_reg;
    logic signed [23:0]  r_reg;
    logic [16:0]         c_reg;
    logic [33:0]         wc_reg, wp_reg;
    pass_t               out_reg;

    logic signed [56:0]  prod_full [3];
    logic [39:0]         px [3];
    logic signed [21:0]  fa [3];
    logic [7:0]          a_idx, b_idx;
    logic signed [17:0]  fx, fy, fz, gx, gy, gz;
    logic signed [20:0]  d1 [4];
    logic signed [24:0]  d2 [2];
    logic signed [24:0]  d3;
    logic signed [23:0]  rc;
    logic [17:0]         sum1, sum2;
    logic [16:0]         nv;
    logic                active;

    assign active = (CNT_W'(OCT) < cfg.n_oct);

    // Lattice position, fade inputs, hash indexes, corner offsets and blend differences.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod_full[a] = $signed(in_pass.coord[a]) * $signed({1'b0, cfg.base_freq});
            px[a] = prod_reg[a] << OCT;
            fa[a] = $signed({6'b0, px[a][31:16]}) * 22'sd6 - 22'sd983040;
        end
        a_idx = perm_at(px[0][39:32]) + px[1][39:32];
        b_idx = perm_at(px[0][39:32] + 8'd1) + px[1][39:32];
        fx = $signed({2'b0, frac4_reg[0]});
        fy = $signed({2'b0, frac4_reg[1]});
        fz = $signed({2'b0, frac4_reg[2]});
        gx = fx - 18'sd65536;
        gy = fy - 18'sd65536;
        gz = fz - 18'sd65536;
        for (int m = 0; m < 4; m++) begin
            d1[m] = 21'(grad_reg[2*m+1]) - 21'(grad_reg[2*m]);
        end
        for (int m = 0; m < 2; m++) begin
            d2[m] = 25'(l1_reg[2*m+1]) - 25'(l1_reg[2*m]);
        end
        d3 = 25'(l2_reg[1]) - 25'(l2_reg[0]);
        // Clamp the blend to [-1, 1] and apply the first of the two halvings; c_reg applies the second.
        if (r_reg > 24'sd65536) begin
            rc = 24'sd65536;
        end else if (r_reg < -24'sd65536) begin
            rc = -24'sd65536;
        end else begin
            rc = r_reg;
        end
        sum1 = 18'(rc + 24'sd65536);
        nv   = sum1[17:1];
        sum2 = 18'(ONE_Q) + {1'b0, nv};
    end

    // Pipeline registers; only the valid bits of the line and the output are reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[1].coord <= in_pass.coord;
            line_reg[1].acc   <= in_pass.acc;
            line_reg[1].wsum  <= in_pass.wsum;
            line_reg[1].w     <= in_pass.w;
            for (int k = 2; k <= LINE; k++) begin
                line_reg[k].coord <= line_reg[k-1].coord;
                line_reg[k].acc   <= line_reg[k-1].acc;
                line_reg[k].wsum  <= line_reg[k-1].wsum;
                line_reg[k].w     <= line_reg[k-1].w;
            end

            for (int a = 0; a < 3; a++) begin
                prod_reg[a]  <= prod_full[a][39:0];
                ta_reg[a]    <= $signed({1'b0, px[a][31:16]}) * fa[a];
                tt_reg[a]    <= px[a][31:16] * px[a][31:16];
                frac2_reg[a] <= px[a][31:16];
                b_reg[a]     <= 23'(ta_reg[a] >>> FRAC_BITS) + 23'sd655360;
                t3p_reg[a]   <= tt_reg[a][31:16] * frac2_reg[a];
                frac3_reg[a] <= frac2_reg[a];
                fp_reg[a]    <= $signed({1'b0, t3p_reg[a][31:16]}) * b_reg[a];
                frac4_reg[a] <= frac3_reg[a];
                fade_reg[a]  <= 18'(fp_reg[a] >>> FRAC_BITS);
            end

            ha_reg  <= a_idx;
            hb_reg  <= b_idx;
            cz2_reg <= px[2][39:32];
            corner_reg[0] <= perm_at(ha_reg) + cz2_reg;
            corner_reg[1] <= perm_at(hb_reg) + cz2_reg;
            corner_reg[2] <= perm_at(ha_reg + 8'd1) + cz2_reg;
            corner_reg[3] <= perm_at(hb_reg + 8'd1) + cz2_reg;
            for (int j = 0; j < 4; j++) begin
                h_reg[j]   <= 4'(perm_at(corner_reg[j]));
                h_reg[j+4] <= 4'(perm_at(corner_reg[j] + 8'd1));
            end

            // Corner gradients; bit 0 of the corner picks x+1, bit 1 y+1, bit 2 z+1.
            grad_reg[0] <= grad_dot(h_reg[0], fx, fy, fz);
            grad_reg[1] <= grad_dot(h_reg[1], gx, fy, fz);
            grad_reg[2] <= grad_dot(h_reg[2], fx, gy, fz);
            grad_reg[3] <= grad_dot(h_reg[3], gx, gy, fz);
            grad_reg[4] <= grad_dot(h_reg[4], fx, fy, gz);
            grad_reg[5] <= grad_dot(h_reg[5], gx, fy, gz);
            grad_reg[6] <= grad_dot(h_reg[6], fx, gy, gz);
            grad_reg[7] <= grad_dot(h_reg[7], gx, gy, gz);

            // Trilinear blend, one multiply stage and one add stage per axis.
            for (int m = 0; m < 4; m++) begin
                l1a_reg[m] <= grad_reg[2*m];
                l1p_reg[m] <= d1[m] * fade_reg[0];
                l1_reg[m]  <= 24'(39'(l1a_reg[m]) + (l1p_reg[m] >>> FRAC_BITS));
            end
            fv6_reg <= fade_reg[1];
            fw6_reg <= fade_reg[2];
            fv7_reg <= fv6_reg;
            fw7_reg <= fw6_reg;
            for (int m = 0; m < 2; m++) begin
                l2a_reg[m] <= l1_reg[2*m];
                l2p_reg[m] <= d2[m] * fv7_reg;
                l2_reg[m]  <= 24'(43'(l2a_reg[m]) + (l2p_reg[m] >>> FRAC_BITS));
            end
            fw8_reg <= fw7_reg;
            fw9_reg <= fw8_reg;
            l3a_reg <= l2_reg[0];
            l3p_reg <= d3 * fw9_reg;
            r_reg   <= 24'(43'(l3a_reg) + (l3p_reg >>> FRAC_BITS));
            c_reg   <= sum2[17:1];

            // Weighted accumulation and next octave weight.
            wc_reg <= line_reg[LINE-1].w * c_reg;
            wp_reg <= line_reg[LINE-1].w * cfg.pers;
            out_reg.coord <= line_reg[LINE].coord;
            if (active) begin
                out_reg.acc  <= line_reg[LINE].acc + ACC_W'(wc_reg);
                out_reg.wsum <= line_reg[LINE].wsum + WSUM_W'(line_reg[LINE].w);
                out_reg.w    <= wp_reg[FRAC_BITS +: W_W];
            end else begin
                out_reg.acc  <= line_reg[LINE].acc;
                out_reg.wsum <= line_reg[LINE].wsum;
                out_reg.w    <= line_reg[LINE].w;
            end
        end

        // Valid bits of the pass-through line and the output.
        if (!aresetn) begin
            for (int k = 1; k <= LINE; k++) begin
                line_reg[k].valid <= 1'b0;
            end
            out_reg.valid <= 1'b0;
        end else if (en) begin
            line_reg[1].valid <= in_pass.valid;
            for (int k = 2; k <= LINE; k++) begin
                line_reg[k].valid <= line_reg[k-1].valid;
            end
            out_reg.valid <= line_reg[LINE].valid;
        end
    end

    assign out_pass = out_reg;

endmodule

// File: sv/fgn_div_cell.sv
module fgn_div_cell
    import fgn_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  div_t in_d,
    output div_t out_d
);

    div_t               d_reg;
    logic [ACC_W:0]     trial;
    logic [Q_W-1:0]     q_next;
    logic [ACC_W-1:0]   rem_next;

    // One restoring step: subtract the shifted divisor if it fits.
    always_comb begin
        trial    = {1'b0, in_d.rem} - ((ACC_W+1)'(in_d.den) << BIT);
        q_next   = in_d.q;
        rem_next = in_d.rem;
        if (!trial[ACC_W]) begin
            rem_next    = trial[ACC_W-1:0];
            q_next[BIT] = 1'b1;
        end
    end

    // Stage register; only the valid bit is reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg.rem <= rem_next;
            d_reg.den <= in_d.den;
            d_reg.q   <= q_next;
        end
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg.valid <= in_d.valid;
        end
    end

    assign out_d = d_reg;

endmodule
